// ----- design/pasfl_pkg.sv -----
// Shared types and constants for the primitive assembly block.
`timescale 1ns / 1ps

package pasfl_pkg;

    // Port width of a vertex handle and the default stored width.
    localparam int VERT_W            = 32;
    localparam int DEF_VERTEX_WIDTH  = 32;

    // Primitive mode codes; every other code passes vertices through.
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_PASS       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINE_STRIP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINE_LOOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRI_STRIP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRI_FAN    = 3'd4;

    // Up to four output vertices per input item.
    localparam int JOB_VERTS = 4;
    localparam int JOB_IDX_W = 2;

    // Depth of the job queue between front and back.
    localparam int JOBQ_DEPTH = 2;

    typedef struct packed {
        logic [JOB_VERTS-1:0][VERT_W-1:0] verts;
        logic [JOB_IDX_W-1:0]             last_idx;
    } t_job;

endpackage

// ----- design/pasfl_front.sv -----
// Front end: accepts vertices, tracks strip/fan/loop state and builds jobs.
`timescale 1ns / 1ps

module pasfl_front #(
    parameter int VERTEX_WIDTH = pasfl_pkg::DEF_VERTEX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pasfl_pkg::MODE_W-1:0]  i_cfg_wdata,
    input  logic                          i_accept,
    input  logic [pasfl_pkg::VERT_W-1:0]  i_vertex_handle,
    input  logic                          i_end_of_draw,
    output logic                          o_job_valid,
    output pasfl_pkg::t_job               o_job
);
    import pasfl_pkg::*;

    localparam int STORE_W = (VERTEX_WIDTH < VERT_W) ? VERTEX_WIDTH : VERT_W;

    logic [MODE_W-1:0]  r_mode;
    logic [STORE_W-1:0] r_q0, n_q0;
    logic [STORE_W-1:0] r_q1, n_q1;
    logic [1:0]         r_qc, n_qc;
    logic [STORE_W-1:0] r_first, n_first;
    logic               r_await, n_await;
    logic               r_odd, n_odd;

    logic [STORE_W-1:0] v;
    logic [STORE_W-1:0] first_eff;
    logic [1:0]         qc;
    logic               is_line, is_loop, is_tri, is_strip;
    logic [VERT_W-1:0]  x_v, x_q0, x_q1, x_first;

    assign v         = i_vertex_handle[STORE_W-1:0];
    assign is_line   = (r_mode == MODE_LINE_STRIP) || (r_mode == MODE_LINE_LOOP);
    assign is_loop   = (r_mode == MODE_LINE_LOOP);
    assign is_tri    = (r_mode == MODE_TRI_STRIP) || (r_mode == MODE_TRI_FAN);
    assign is_strip  = (r_mode == MODE_TRI_STRIP);
    assign first_eff = (is_loop && r_await) ? r_q0 : r_first;

    // Zero-extend stored handles to the port width.
    always_comb begin
        x_v     = '0;
        x_q0    = '0;
        x_q1    = '0;
        x_first = '0;
        x_v[STORE_W-1:0]     = v;
        x_q0[STORE_W-1:0]    = r_q0;
        x_q1[STORE_W-1:0]    = r_q1;
        x_first[STORE_W-1:0] = first_eff;
    end

    always_comb begin
        n_q0        = r_q0;
        n_q1        = r_q1;
        n_qc        = r_qc;
        n_first     = r_first;
        n_await     = r_await;
        n_odd       = r_odd;
        o_job_valid = 1'b0;
        o_job       = '0;
        qc          = r_qc;

        if (is_line) begin
            qc = (r_qc > 2'd1) ? 2'd1 : r_qc;
            if (qc == 2'd0) begin
                n_q0 = v;
                n_qc = 2'd1;
            end else begin
                o_job_valid    = 1'b1;
                o_job.verts[0] = x_q0;
                o_job.verts[1] = x_v;
                o_job.last_idx = 2'd1;
                if (is_loop && r_await) begin
                    n_first = r_q0;
                    n_await = 1'b0;
                end
                // Close the loop back to its first vertex.
                if (i_end_of_draw && is_loop) begin
                    o_job.verts[2] = x_v;
                    o_job.verts[3] = x_first;
                    o_job.last_idx = 2'd3;
                end
                n_q0 = v;
                n_qc = 2'd1;
            end
            if (i_end_of_draw && is_loop) begin
                n_await = 1'b1;
            end
        end else if (is_tri) begin
            qc = (r_qc > 2'd2) ? 2'd2 : r_qc;
            if (qc == 2'd0) begin
                n_q0 = v;
                n_qc = 2'd1;
            end else if (qc == 2'd1) begin
                n_q1 = v;
                n_qc = 2'd2;
            end else begin
                o_job_valid    = 1'b1;
                o_job.verts[0] = x_q0;
                o_job.verts[1] = x_q1;
                o_job.verts[2] = x_v;
                o_job.last_idx = 2'd2;
                if (is_strip && !r_odd) begin
                    n_q0 = v;
                    n_q1 = r_q1;
                end else begin
                    n_q0 = r_q0;
                    n_q1 = v;
                end
                if (is_strip) begin
                    n_odd = !r_odd;
                end
                n_qc = 2'd2;
            end
        end else begin
            o_job_valid    = 1'b1;
            o_job.verts[0] = x_v;
            o_job.last_idx = 2'd0;
        end

        if (i_end_of_draw) begin
            n_qc  = 2'd0;
            n_odd = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PASS;
            r_qc    <= 2'd0;
            r_await <= 1'b1;
            r_odd   <= 1'b0;
        end else if (i_cfg_we) begin
            // A new mode starts a new draw; rewriting the same mode is a no-op.
            if (i_cfg_wdata != r_mode) begin
                r_mode  <= i_cfg_wdata;
                r_qc    <= 2'd0;
                r_await <= 1'b1;
                r_odd   <= 1'b0;
            end
        end else if (i_accept) begin
            r_qc    <= n_qc;
            r_await <= n_await;
            r_odd   <= n_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_cfg_we) begin
            r_q0    <= n_q0;
            r_q1    <= n_q1;
            r_first <= n_first;
        end
    end

endmodule

// ----- design/pasfl_job_fifo.sv -----
// Short job queue decoupling the front end from the emit stage.
`timescale 1ns / 1ps

module pasfl_job_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pasfl_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pasfl_pkg::t_job o_job
);
    import pasfl_pkg::*;

    localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    t_job             r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- design/pasfl_back.sv -----
// Emit stage: walks a job one vertex per cycle into the output register while the receiver pops.
`timescale 1ns / 1ps

module pasfl_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_empty,
    input  pasfl_pkg::t_job              i_job,
    output logic                         o_job_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [pasfl_pkg::VERT_W-1:0] o_out_vertex,
    output logic                         o_run_last
);
    import pasfl_pkg::*;

    logic [JOB_IDX_W-1:0] r_idx;
    logic                 r_valid;
    logic [VERT_W-1:0]    r_vertex;
    logic                 r_last;
    logic                 load, at_last;

    assign load      = !i_job_empty && (!r_valid || i_pop);
    assign at_last   = (r_idx == i_job.last_idx);
    assign o_job_pop = load && at_last;

    assign o_empty      = !r_valid;
    assign o_out_vertex = r_vertex;
    assign o_run_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_last ? '0 : r_idx + 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vertex <= i_job.verts[r_idx];
            r_last   <= at_last;
        end
    end

endmodule

// ----- design/primitive_assembly_strip_fan_loop.sv -----
// Top level of the strip, fan and loop primitive assembler.
`timescale 1ns / 1ps

// Usage:
// - Input queue port: drive i_vertex_handle and i_end_of_draw with i_push;
//   a transfer happens on a clock edge with i_push high and o_full low.
// - Result queue port: while o_empty is low, o_out_vertex and o_run_last
//   hold the oldest result; a transfer happens with i_pop high and o_empty low.
//   o_run_last marks the final vertex produced for one input vertex.
// - Config: i_cfg_we with i_cfg_wdata sets the primitive mode; write only
//   while idle. Changing the mode starts a new draw.
// - Path: the first vertex of a run goes from its input transfer into the job
//   queue and then into the output register before it is on the result ports.
// - Output: the emit stage sends one vertex per cycle while the receiver pops; an
//   input yields one vertex in pass-through, two in line modes (four when a loop
//   closes) and three in triangle modes, none if it only primes the queue. The
//   front accepts a new input every cycle while the job queue has room.
// - Reset: mode goes to pass-through, vertex queue and job queue empty.
// - Stall: when the receiver holds off, the output register keeps its value,
//   the job queue fills, and o_full rises to hold off the sender.

module primitive_assembly_strip_fan_loop #(
    parameter int VERTEX_WIDTH = pasfl_pkg::DEF_VERTEX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pasfl_pkg::MODE_W-1:0] i_cfg_wdata,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [pasfl_pkg::VERT_W-1:0] i_vertex_handle,
    input  logic                         i_end_of_draw,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [pasfl_pkg::VERT_W-1:0] o_out_vertex,
    output logic                         o_run_last
);
    import pasfl_pkg::*;

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job head_job;
    logic jq_empty;
    logic jq_pop;

    // Take an input whenever the job queue has room.
    assign accept = i_push && !o_full;

    pasfl_front #(
        .VERTEX_WIDTH(VERTEX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_vertex_handle(i_vertex_handle),
        .i_end_of_draw  (i_end_of_draw),
        .o_job_valid    (job_valid),
        .o_job          (front_job)
    );

    // Inputs that only prime the queue produce no job and are dropped here.
    pasfl_job_fifo u_jobq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept && job_valid),
        .i_job  (front_job),
        .i_pop  (jq_pop),
        .o_full (o_full),
        .o_empty(jq_empty),
        .o_job  (head_job)
    );

    pasfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (jq_empty),
        .i_job       (head_job),
        .o_job_pop   (jq_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_vertex(o_out_vertex),
        .o_run_last  (o_run_last)
    );

endmodule
